### src/packed_key_value_table_defines.svh
// Assertion macros shared by the packed key/value table RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef PACKED_KEY_VALUE_TABLE_DEFINES_SVH
`define PACKED_KEY_VALUE_TABLE_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define PKVT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define PKVT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/pkvt_pkg.sv
// Package for the packed key/value table: field widths, command and status
// codes, controller states and the update controls sent to the cells. No dependencies.
package pkvt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int CMD_W        = 2;
    localparam int KEY_W        = 32;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;
    localparam int TOTAL_W      = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_MISSING = 2'd1,
        STS_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_APPLY
    } state_t;

    // Update controls broadcast to every cell for one cycle.
    typedef struct packed {
        logic shift_en;   // remove: cells at or past the index take their neighbour's pair
        logic append_en;  // write of a new key: the cell at the index loads the pair
        logic update_en;  // write of a known key: the hit cell loads the value
    } apply_t;

endpackage

### src/packed_key_value_table.sv
// Packed key/value table: top level with the controller and the row of cells.
// Depends on pkvt_pkg, pkvt_cell, pkvt_reduce and packed_key_value_table_defines.svh.
//
// Usage
//   Input channel (in_valid/in_ready) carries one command word: command, key,
//   value. Commands are read, write (insert or update), remove and clear.
//   Output channel (out_valid/out_ready) returns one result word per command:
//   status, read_value and entry_total (entries held after the command).
// Timing
//   Each cell compares its key at the accepting edge; the reduce step then
//   registers the reduced found/index/value; the apply step then updates the
//   row (shift on remove, append, update) and loads the result register. A
//   command is taken only in the idle state, so a new one waits until the
//   last has gone through the compare -> reduce -> apply steps of the cell
//   row.
// Reset and stalls
//   Reset empties the table (count zero); slot contents stay undefined and
//   are never read before being written. While a result waits on out_ready
//   the block still accepts a new command, then holds it in the apply step
//   until the result register is free.
`include "packed_key_value_table_defines.svh"

module packed_key_value_table #(
    parameter int CAPACITY = pkvt_pkg::CAPACITY_DEF,
    localparam int IDX_W   = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pkvt_pkg::CMD_W-1:0]    command,
    input  logic [pkvt_pkg::KEY_W-1:0]    key,
    input  logic [pkvt_pkg::VALUE_W-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pkvt_pkg::STATUS_W-1:0] status,
    output logic [pkvt_pkg::VALUE_W-1:0]  read_value,
    output logic [pkvt_pkg::TOTAL_W-1:0]  entry_total
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    pkvt_pkg::state_t             state_reg;
    pkvt_pkg::state_t             state_next;
    pkvt_pkg::cmd_t               cmd_reg;
    logic [pkvt_pkg::KEY_W-1:0]   key_reg;
    logic [pkvt_pkg::VALUE_W-1:0] value_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    pkvt_pkg::status_t            status_reg;
    pkvt_pkg::status_t            status_next;
    logic [pkvt_pkg::VALUE_W-1:0] rdval_reg;
    logic [pkvt_pkg::VALUE_W-1:0] rdval_next;

    logic                         accept;
    logic                         apply_fire;
    pkvt_pkg::apply_t             ctrl;
    logic [IDX_W-1:0]             sel_idx;

    logic [CAPACITY-1:0]                        hit_vec;
    logic [CAPACITY-1:0][pkvt_pkg::KEY_W-1:0]   key_vec;
    logic [CAPACITY-1:0][pkvt_pkg::VALUE_W-1:0] value_vec;
    logic                                       found;
    logic [IDX_W-1:0]                           found_idx;
    logic [pkvt_pkg::VALUE_W-1:0]               found_value;

    assign in_ready   = (state_reg == pkvt_pkg::ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign apply_fire = (state_reg == pkvt_pkg::ST_APPLY) && (!out_valid_reg || out_ready);

    // Row of cells: each slot hands its pair to the slot below on a remove.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [pkvt_pkg::KEY_W-1:0]   nbr_key;
        logic [pkvt_pkg::VALUE_W-1:0] nbr_value;

        if (g == CAPACITY - 1)
        begin : g_last
            assign nbr_key   = key_vec[g];
            assign nbr_value = value_vec[g];
        end
        else
        begin : g_mid
            assign nbr_key   = key_vec[g+1];
            assign nbr_value = value_vec[g+1];
        end

        pkvt_cell #(
            .CAPACITY   (CAPACITY),
            .CELL_INDEX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmp_en    (accept),
            .cmp_key   (key),
            .count     (count_reg),
            .ctrl      (ctrl),
            .sel_idx   (sel_idx),
            .new_key   (key_reg),
            .new_value (value_reg),
            .nbr_key   (nbr_key),
            .nbr_value (nbr_value),
            .key       (key_vec[g]),
            .value     (value_vec[g]),
            .hit       (hit_vec[g])
        );
    end

    pkvt_reduce #(
        .CAPACITY (CAPACITY)
    ) u_reduce (
        .clk         (clk),
        .load_en     (state_reg == pkvt_pkg::ST_REDUCE),
        .hit_vec     (hit_vec),
        .value_vec   (value_vec),
        .found       (found),
        .found_idx   (found_idx),
        .found_value (found_value)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pkvt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = pkvt_pkg::ST_REDUCE;
                end
            end
            pkvt_pkg::ST_REDUCE:
            begin
                state_next = pkvt_pkg::ST_APPLY;
            end
            pkvt_pkg::ST_APPLY:
            begin
                if (apply_fire)
                begin
                    state_next = pkvt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pkvt_pkg::ST_IDLE;
            end
        endcase
    end

    // Apply step: decide the row update, the new count and the result word.
    always_comb
    begin
        ctrl           = '0;
        sel_idx        = found_idx;
        count_next     = count_reg;
        status_next    = status_reg;
        rdval_next     = rdval_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (apply_fire)
        begin
            out_valid_next = 1'b1;
            status_next    = pkvt_pkg::STS_OK;
            rdval_next     = '0;
            unique case (cmd_reg)
                pkvt_pkg::CMD_READ:
                begin
                    if (found)
                    begin
                        rdval_next = found_value;
                    end
                    else
                    begin
                        status_next = pkvt_pkg::STS_MISSING;
                    end
                end
                pkvt_pkg::CMD_WRITE:
                begin
                    if (found)
                    begin
                        ctrl.update_en = 1'b1;
                    end
                    else if (count_reg == FULL_CNT)
                    begin
                        status_next = pkvt_pkg::STS_FULL;
                    end
                    else
                    begin
                        ctrl.append_en = 1'b1;
                        sel_idx        = count_reg[IDX_W-1:0];
                        count_next     = count_reg + CNT_W'(1);
                    end
                end
                pkvt_pkg::CMD_REMOVE:
                begin
                    if (found)
                    begin
                        ctrl.shift_en = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = pkvt_pkg::STS_MISSING;
                    end
                end
                pkvt_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pkvt_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the command word for the apply step; hold the result until taken.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= pkvt_pkg::cmd_t'(command);
            key_reg   <= key;
            value_reg <= value;
        end
        status_reg <= status_next;
        rdval_reg  <= rdval_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_value  = rdval_reg;
    assign entry_total = pkvt_pkg::TOTAL_W'(count_reg);

    // Keys in occupied slots are unique, so no command ever hits twice.
    `PKVT_ASSERT(a_single_hit, $onehot0(hit_vec), "more than one cell hit")
    `PKVT_ASSERT(a_count_bound, count_reg <= FULL_CNT, "entry count beyond capacity")
    `PKVT_ASSERT(a_count_only_on_apply, !apply_fire |=> $stable(count_reg), "stray count update")
    `PKVT_ASSERT(a_accept_reduce, accept |=> state_reg == pkvt_pkg::ST_REDUCE, "no reduce step")

endmodule

### src/pkvt_cell.sv
// One slot of the packed key/value table: key, value and a registered hit flag.
// Depends on pkvt_pkg.
module pkvt_cell #(
    parameter int CAPACITY   = pkvt_pkg::CAPACITY_DEF,
    parameter int CELL_INDEX = 0,
    localparam int IDX_W     = $clog2(CAPACITY),
    localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmp_en,
    input  logic [pkvt_pkg::KEY_W-1:0]   cmp_key,
    input  logic [CNT_W-1:0]             count,
    input  pkvt_pkg::apply_t             ctrl,
    input  logic [IDX_W-1:0]             sel_idx,
    input  logic [pkvt_pkg::KEY_W-1:0]   new_key,
    input  logic [pkvt_pkg::VALUE_W-1:0] new_value,
    input  logic [pkvt_pkg::KEY_W-1:0]   nbr_key,
    input  logic [pkvt_pkg::VALUE_W-1:0] nbr_value,
    output logic [pkvt_pkg::KEY_W-1:0]   key,
    output logic [pkvt_pkg::VALUE_W-1:0] value,
    output logic                         hit
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);
    localparam bit               IS_LAST = (CELL_INDEX == CAPACITY - 1);

    logic [pkvt_pkg::KEY_W-1:0]   key_reg;
    logic [pkvt_pkg::VALUE_W-1:0] value_reg;
    logic                         hit_reg;
    logic                         occupied;
    logic                         take_nbr;
    logic                         take_new;
    logic                         take_val;

    assign occupied = (MY_CNT < count);
    assign take_nbr = ctrl.shift_en && !IS_LAST && (MY_IDX >= sel_idx);
    assign take_new = ctrl.append_en && (MY_IDX == sel_idx);
    assign take_val = ctrl.update_en && hit_reg;

    // Compare against the incoming key as the command is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmp_en)
        begin
            hit_reg <= occupied && (key_reg == cmp_key);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_nbr)
        begin
            key_reg   <= nbr_key;
            value_reg <= nbr_value;
        end
        else if (take_new)
        begin
            key_reg   <= new_key;
            value_reg <= new_value;
        end
        else if (take_val)
        begin
            value_reg <= new_value;
        end
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign hit   = hit_reg;

endmodule

### src/pkvt_reduce.sv
// Combines the per-cell hit flags into found, slot index and read value, registered.
// Depends on pkvt_pkg.
module pkvt_reduce #(
    parameter int CAPACITY = pkvt_pkg::CAPACITY_DEF,
    localparam int IDX_W   = $clog2(CAPACITY)
) (
    input  logic                                       clk,
    input  logic                                       load_en,
    input  logic [CAPACITY-1:0]                        hit_vec,
    input  logic [CAPACITY-1:0][pkvt_pkg::VALUE_W-1:0] value_vec,
    output logic                                       found,
    output logic [IDX_W-1:0]                           found_idx,
    output logic [pkvt_pkg::VALUE_W-1:0]               found_value
);

    logic                         found_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [pkvt_pkg::VALUE_W-1:0] rdval_reg;
    logic [IDX_W-1:0]             idx_next;
    logic [pkvt_pkg::VALUE_W-1:0] rdval_next;

    // At most one cell hits, so an OR of masked terms encodes and selects.
    always_comb
    begin
        idx_next   = '0;
        rdval_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            idx_next   = idx_next | ({IDX_W{hit_vec[i]}} & IDX_W'(i));
            rdval_next = rdval_next | ({pkvt_pkg::VALUE_W{hit_vec[i]}} & value_vec[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            found_reg <= |hit_vec;
            idx_reg   <= idx_next;
            rdval_reg <= rdval_next;
        end
    end

    assign found       = found_reg;
    assign found_idx   = idx_reg;
    assign found_value = rdval_reg;

endmodule

### bench/tb_packed_key_value_table.sv
// Self-checking bench for the packed key/value table: directed and random command words,
// a cycle-free table predictor and a scoreboard on the result channel.
// Depends on pkvt_pkg and the packed_key_value_table RTL.
`timescale 1ns / 1ps

module tb_packed_key_value_table;

    localparam int TABLE_DEPTH  = pkvt_pkg::CAPACITY_DEF;
    localparam int IDLE_PCT     = 33;
    // Word counts between which neither side idles.
    localparam int CALM_FROM    = 400;
    localparam int CALM_TO      = 540;
    // Long receiver hold-off: length and the result counts that trigger it.
    localparam int HOLD_CYCLES  = 80;
    localparam int FIRST_HOLD   = 150;
    localparam int HOLD_SPACING = 550;
    localparam int RANDOM_WORDS = 900;
    localparam int DRAIN_CYCLES = 20;

    // One command word as offered on the input channel.
    typedef struct {
        pkvt_pkg::cmd_t                 op;
        logic [pkvt_pkg::KEY_W-1:0]     key;
        logic [pkvt_pkg::VALUE_W-1:0]   value;
    } table_cmd_word_t;

    // One result word as expected on the output channel.
    typedef struct {
        pkvt_pkg::status_t              status;
        logic [pkvt_pkg::VALUE_W-1:0]   read_value;
        logic [pkvt_pkg::TOTAL_W-1:0]   entry_total;
    } table_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [pkvt_pkg::CMD_W-1:0]      command = '0;
    logic [pkvt_pkg::KEY_W-1:0]      key = '0;
    logic [pkvt_pkg::VALUE_W-1:0]    value = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [pkvt_pkg::STATUS_W-1:0]   status;
    logic [pkvt_pkg::VALUE_W-1:0]    read_value;
    logic [pkvt_pkg::TOTAL_W-1:0]    entry_total;

    // Predicted table contents: slots 0 .. held_total-1 are live.
    logic [pkvt_pkg::KEY_W-1:0]      held_keys   [TABLE_DEPTH];
    logic [pkvt_pkg::VALUE_W-1:0]    held_values [TABLE_DEPTH];
    int                              held_total = 0;

    table_cmd_word_t                 queued_commands [$];
    table_result_t                   due_results [$];

    int                              total_words = 0;
    int                              n_offered = 0;
    int                              n_accepted = 0;
    int                              n_results = 0;
    int                              fault_count = 0;
    int                              hold_left = 0;
    int                              next_hold_at = FIRST_HOLD;

    packed_key_value_table uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .read_value  (read_value),
        .entry_total (entry_total)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Apply one command to the predicted table and return the result it must yield.
    // Lookups only ever touch live slots, so unwritten slots are never read.
    function automatic table_result_t table_apply(pkvt_pkg::cmd_t op,
                                                  logic [pkvt_pkg::KEY_W-1:0] k,
                                                  logic [pkvt_pkg::VALUE_W-1:0] v);
        table_result_t res;
        int hit;
        res.status     = pkvt_pkg::STS_OK;
        res.read_value = '0;
        hit            = -1;
        if (op == pkvt_pkg::CMD_CLEAR)
        begin
            held_total = 0;
        end
        else
        begin
            for (int i = 0; i < held_total; i++)
                if (hit < 0 && held_keys[i] == k)
                    hit = i;
            case (op)
                pkvt_pkg::CMD_READ:
                begin
                    if (hit >= 0)
                        res.read_value = held_values[hit];
                    else
                        res.status = pkvt_pkg::STS_MISSING;
                end
                pkvt_pkg::CMD_WRITE:
                begin
                    // A known key is updated even when the table is full.
                    if (hit >= 0)
                        held_values[hit] = v;
                    else if (held_total >= TABLE_DEPTH)
                        res.status = pkvt_pkg::STS_FULL;
                    else
                    begin
                        held_keys[held_total]   = k;
                        held_values[held_total] = v;
                        held_total++;
                    end
                end
                pkvt_pkg::CMD_REMOVE:
                begin
                    if (hit < 0)
                        res.status = pkvt_pkg::STS_MISSING;
                    else
                    begin
                        // Close the gap: every later entry moves one slot down.
                        for (int i = hit; i < held_total - 1; i++)
                        begin
                            held_keys[i]   = held_keys[i + 1];
                            held_values[i] = held_values[i + 1];
                        end
                        held_total--;
                    end
                end
                default: ;
            endcase
        end
        res.entry_total = pkvt_pkg::TOTAL_W'(held_total);
        return res;
    endfunction

    function automatic void queue_word(pkvt_pkg::cmd_t op, logic [pkvt_pkg::KEY_W-1:0] k,
                                       logic [pkvt_pkg::VALUE_W-1:0] v);
        table_cmd_word_t w;
        w.op    = op;
        w.key   = k;
        w.value = v;
        queued_commands.push_back(w);
    endfunction

    // Stimulus: a directed opening, then random segments of traffic until the
    // random word budget is spent.
    initial
    begin
        int                         mode;
        int                         seg_len;
        int                         pool_n;
        int                         random_made;
        int                         w_read;
        int                         w_write;
        int                         w_remove;
        int                         roll;
        logic [pkvt_pkg::KEY_W-1:0] pick;
        logic [pkvt_pkg::KEY_W-1:0] key_pool [$];
        pkvt_pkg::cmd_t             op;

        // Empty table: read and remove both miss.
        queue_word(pkvt_pkg::CMD_READ,   32'h0000_0000, $urandom());
        queue_word(pkvt_pkg::CMD_REMOVE, 32'h0000_0005, $urandom());
        // Extreme keys and values, including a key stored with value zero.
        queue_word(pkvt_pkg::CMD_WRITE,  32'h8000_0000, 32'h7FFF_FFFF);
        queue_word(pkvt_pkg::CMD_WRITE,  32'h7FFF_FFFF, 32'h8000_0000);
        queue_word(pkvt_pkg::CMD_WRITE,  32'h0000_0000, 32'hFFFF_FFFF);
        queue_word(pkvt_pkg::CMD_WRITE,  32'hFFFF_FFFF, 32'h0000_0000);
        queue_word(pkvt_pkg::CMD_WRITE,  32'h0000_0001, 32'hAAAA_AAAA);
        queue_word(pkvt_pkg::CMD_READ,   32'h8000_0000, $urandom());
        queue_word(pkvt_pkg::CMD_READ,   32'h7FFF_FFFF, $urandom());
        queue_word(pkvt_pkg::CMD_READ,   32'hFFFF_FFFF, $urandom());
        // Update in place, then a read miss.
        queue_word(pkvt_pkg::CMD_WRITE,  32'h0000_0000, 32'h5555_5555);
        queue_word(pkvt_pkg::CMD_READ,   32'h0000_0000, $urandom());
        queue_word(pkvt_pkg::CMD_READ,   32'h0000_0002, $urandom());
        // Remove from the middle, the end and the front; a remove miss in between.
        queue_word(pkvt_pkg::CMD_REMOVE, 32'h7FFF_FFFF, $urandom());
        queue_word(pkvt_pkg::CMD_READ,   32'hFFFF_FFFF, $urandom());
        queue_word(pkvt_pkg::CMD_READ,   32'h0000_0001, $urandom());
        queue_word(pkvt_pkg::CMD_REMOVE, 32'h0000_0001, $urandom());
        queue_word(pkvt_pkg::CMD_REMOVE, 32'h0000_0001, $urandom());
        queue_word(pkvt_pkg::CMD_REMOVE, 32'h8000_0000, $urandom());
        queue_word(pkvt_pkg::CMD_READ,   32'h8000_0000, $urandom());
        // Clear a populated table, then an empty one.
        queue_word(pkvt_pkg::CMD_CLEAR,  $urandom(), $urandom());
        queue_word(pkvt_pkg::CMD_READ,   32'h0000_0000, $urandom());
        queue_word(pkvt_pkg::CMD_CLEAR,  $urandom(), $urandom());
        queue_word(pkvt_pkg::CMD_WRITE,  32'h1234_5678, 32'h5A5A_5A5A);

        random_made = 0;
        while (random_made < RANDOM_WORDS)
        begin
            roll = $urandom_range(0, 99);
            mode = (roll < 25) ? 0 : (roll < 55) ? 1 : (roll < 85) ? 2 : 3;
            key_pool.delete();
            case (mode)
                0:
                begin
                    pool_n = $urandom_range(2, 12);
                    w_read = 30; w_write = 35; w_remove = 30;
                end
                1:
                begin
                    pool_n = TABLE_DEPTH + $urandom_range(2, 8);
                    w_read = 25; w_write = 45; w_remove = 28;
                end
                2:
                begin
                    pool_n = $urandom_range(60, 90);
                    w_read = 25; w_write = 50; w_remove = 22;
                end
                default:
                begin
                    pool_n = 0;
                    w_read = 30; w_write = 30; w_remove = 30;
                end
            endcase
            for (int i = 0; i < pool_n; i++)
                key_pool.push_back($urandom());
            if (pool_n > 0 && $urandom_range(0, 3) == 0)
            begin
                key_pool[0]          = 32'h8000_0000;
                key_pool[pool_n - 1] = 32'h7FFF_FFFF;
            end

            // Fill run: start empty and write every pool key, overrunning the capacity.
            if (mode == 1)
            begin
                queue_word(pkvt_pkg::CMD_CLEAR, $urandom(), $urandom());
                foreach (key_pool[i])
                    queue_word(pkvt_pkg::CMD_WRITE, key_pool[i], $urandom());
                random_made += pool_n + 1;
            end

            seg_len = (mode == 3) ? $urandom_range(20, 40) : $urandom_range(40, 100);
            for (int n = 0; n < seg_len; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < w_read)
                    op = pkvt_pkg::CMD_READ;
                else if (roll < w_read + w_write)
                    op = pkvt_pkg::CMD_WRITE;
                else if (roll < w_read + w_write + w_remove)
                    op = pkvt_pkg::CMD_REMOVE;
                else
                    op = pkvt_pkg::CMD_CLEAR;
                // A few stray keys per segment keep misses and fresh inserts coming.
                if (key_pool.size() == 0 || $urandom_range(0, 99) < 8)
                    pick = $urandom();
                else
                    pick = key_pool[$urandom_range(0, key_pool.size() - 1)];
                queue_word(op, pick, $urandom());
            end
            random_made += seg_len;
        end
        total_words = queued_commands.size();
    end

    // Input driver: change the word at the falling edge. Advance only once the
    // current word has been taken; otherwise hold valid and payload.
    always @(negedge clk)
    begin
        table_cmd_word_t w;
        bit              rest;
        if (rst_n && (!in_valid || n_accepted == n_offered))
        begin
            rest = (n_offered < CALM_FROM || n_offered >= CALM_TO)
                   && ($urandom_range(0, 99) < IDLE_PCT);
            if (queued_commands.size() != 0 && !rest)
            begin
                w = queued_commands.pop_front();
                command  <= w.op;
                key      <= w.key;
                value    <= w.value;
                in_valid <= 1'b1;
                n_offered++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Accepted words: run them through the predictor in acceptance order.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            due_results.push_back(table_apply(pkvt_pkg::cmd_t'(command), key, value));
            n_accepted++;
        end
    end

    // Result receiver: random back-pressure, a calm stretch, and now and then a
    // long hold-off so that the block fills up and stops taking commands.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left == 0 && n_results >= next_hold_at)
            begin
                hold_left    = HOLD_CYCLES;
                next_hold_at = next_hold_at + HOLD_SPACING;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (n_results >= CALM_FROM && n_results < CALM_TO)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Scoreboard: compare each delivered result word with the oldest prediction.
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (due_results.size() == 0)
            begin
                $error("stray result word: status %0d read_value %h entry_total %0d",
                       status, read_value, entry_total);
                fault_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fault_count++;
                end
                if (read_value !== want.read_value)
                begin
                    $error("read_value: expected %h, got %h", want.read_value, read_value);
                    fault_count++;
                end
                if (entry_total !== want.entry_total)
                begin
                    $error("entry_total: expected %0d, got %0d", want.entry_total, entry_total);
                    fault_count++;
                end
            end
        end
    end

    // Sequencing: reset, wait for every word to go in and every result to come
    // back, drain for strays, then give the verdict.
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (total_words == 0 || n_accepted != total_words)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: ends the run with an error if the sequencing never finishes.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/pkvt_pkg.sv
src/pkvt_cell.sv
src/pkvt_reduce.sv
src/packed_key_value_table.sv
bench/tb_packed_key_value_table.sv
